@@ rtl/ptd_pkg.sv @@
// shared types and constants for the periodic task dispatcher
// no dependencies; imported by every other rtl file
`default_nettype none

package ptd_pkg;

  // task table size and index widths
  localparam int MAX_TASKS = 8;
  localparam int TASK_W    = 3;
  localparam int CNT_W     = 4;

  // field widths
  localparam int CMD_W  = 3;
  localparam int STAT_W = 3;
  localparam int MS_W   = 16;
  localparam int IVL_W  = 16;
  localparam int DLY_W  = 16;
  localparam int SHF_W  = 32;
  localparam int EL_W   = 32;
  localparam int LATE_W = 31;

  // stream and register port widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // register indexes
  localparam int REG_PRIORITY_MODE = 0;

  // saturation limits of the elapsed counts
  localparam logic [EL_W-1:0] EL_MAX = {1'b0, {(EL_W-1){1'b1}}};
  localparam logic [EL_W-1:0] EL_MIN = {1'b1, {(EL_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_SHIFT   = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DISPATCHED  = 3'd0,
    STAT_NOTHING_DUE = 3'd1,
    STAT_OK          = 3'd2,
    STAT_FULL        = 3'd3,
    STAT_BAD         = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMD,
    ST_FLUSH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input transaction
    logic step;   // process one table entry of a tick
    logic exec;   // carry out a non-tick command
    logic flush;  // emit the final result of a tick
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_tick;     // offered transaction is a tick
    logic count_zero;  // task table is empty
    logic scan_last;   // current scan entry is the last used one
    logic stall;       // entry cannot be processed, output busy
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/ptd_ctrl.sv @@
// controller state machine for the periodic task dispatcher
// depends on ptd_pkg; drives the datapath via ctrl_cmd_t
`default_nettype none

module ptd_ctrl
  import ptd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load = 1'b1;
          if (!sts_i.in_tick) begin
            state_nxt = ST_CMD;
          end else if (sts_i.count_zero) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!sts_i.stall) begin
          cmd_o.step = 1'b1;
          if (sts_i.scan_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_CMD: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/ptd_datapath.sv @@
// task tables, scan datapath and output register of the dispatcher
// depends on ptd_pkg; sequenced by ptd_ctrl
`default_nettype none

module ptd_datapath
  import ptd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [CMD_W-1:0]      in_tuser,
  input  wire logic                  prio_mode,
  input  wire ctrl_cmd_t             cmd_i,
  output ctrl_sts_t                  sts_o,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [STAT_W-1:0]          out_tuser,
  output logic                       out_tlast
);

  // captured transaction
  logic [CMD_W-1:0]  cmd_r;
  logic [MS_W-1:0]   ems_r;
  logic [TASK_W-1:0] tidx_r;
  logic [IVL_W-1:0]  ivl_r;
  logic              srun_r;
  logic [DLY_W-1:0]  dly_r;
  logic [SHF_W-1:0]  shf_r;

  // task tables
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  idx_r;
  logic [IVL_W-1:0]  period_mem [MAX_TASKS];
  logic              run_mem    [MAX_TASKS];
  logic [EL_W-1:0]   el_mem     [MAX_TASKS];
  logic [LATE_W-1:0] worst_r    [MAX_TASKS];

  // dispatch held back until the next one or the end of the scan
  logic              pend_valid_r;
  logic [TASK_W-1:0] pend_task_r;
  logic [LATE_W-1:0] pend_late_r;
  logic [LATE_W-1:0] pend_worst_r;

  // output register
  logic              out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  logic [TASK_W-1:0] out_task_r;
  logic [LATE_W-1:0] out_late_r;
  logic [LATE_W-1:0] out_worst_r;
  logic              out_last_r;

  // combinational
  logic [TASK_W-1:0] rd_addr;
  logic [IVL_W-1:0]  rd_period;
  logic              rd_run;
  logic [EL_W-1:0]   rd_el;
  logic [LATE_W-1:0] rd_worst;
  logic [EL_W:0]     tick_sum;
  logic [EL_W-1:0]   tick_el;
  logic [EL_W-1:0]   el_new;
  logic [EL_W-1:0]   period_ext;
  logic [EL_W-1:0]   late_full;
  logic [LATE_W-1:0] late;
  logic [LATE_W-1:0] worst_new;
  logic              due;
  logic              hit;
  logic [EL_W:0]     shf_sum;
  logic [EL_W-1:0]   shf_el;
  logic              out_free;
  logic              idx_bad;
  logic              full;
  logic              push;
  logic              out_load;
  logic [STAT_W-1:0] ex_stat;
  logic [TASK_W-1:0] ex_task;
  logic              add_we;
  logic              upd_we;
  logic              upd_run;
  logic [EL_W-1:0]   upd_el;

  // single table read port, scan entry or addressed task
  assign rd_addr   = cmd_i.exec ? tidx_r : idx_r[TASK_W-1:0];
  assign rd_period = period_mem[rd_addr];
  assign rd_run    = run_mem[rd_addr];
  assign rd_el     = el_mem[rd_addr];
  assign rd_worst  = worst_r[rd_addr];

  // tick: saturating add of elapsed milliseconds, then due check
  assign tick_sum   = {rd_el[EL_W-1], rd_el} + {{(EL_W+1-MS_W){1'b0}}, ems_r};
  assign tick_el    = (tick_sum[EL_W] != tick_sum[EL_W-1]) ? EL_MAX : tick_sum[EL_W-1:0];
  assign el_new     = rd_run ? tick_el : rd_el;
  assign period_ext = {{(EL_W-IVL_W){1'b0}}, rd_period};
  assign due        = rd_run && ($signed(el_new) >= $signed(period_ext));
  assign hit        = due && !(prio_mode && pend_valid_r);
  assign late_full  = el_new - period_ext;
  assign late       = late_full[LATE_W-1:0];
  assign worst_new  = (late > rd_worst) ? late : rd_worst;

  // shift: saturating signed add
  assign shf_sum = {rd_el[EL_W-1], rd_el} + {shf_r[SHF_W-1], shf_r};
  always_comb begin
    if (shf_sum[EL_W] != shf_sum[EL_W-1]) begin
      shf_el = shf_sum[EL_W] ? EL_MIN : EL_MAX;
    end else begin
      shf_el = shf_sum[EL_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign idx_bad  = {1'b0, tidx_r} >= cnt_r;
  assign full     = cnt_r >= CNT_W'(MAX_TASKS);
  assign push     = cmd_i.step && hit && pend_valid_r;
  assign out_load = push || cmd_i.exec || cmd_i.flush;

  // non-tick command decode
  always_comb begin
    ex_stat = STAT_BAD;
    ex_task = '0;
    add_we  = 1'b0;
    upd_we  = 1'b0;
    upd_run = rd_run;
    upd_el  = rd_el;
    case (cmd_r)
      CMD_ADD: begin
        if (full) begin
          ex_stat = STAT_FULL;
        end else begin
          ex_stat = STAT_OK;
          ex_task = cnt_r[TASK_W-1:0];
          add_we  = 1'b1;
        end
      end
      CMD_RESUME, CMD_SUSPEND, CMD_SHIFT: begin
        ex_task = tidx_r;
        if (!idx_bad) begin
          ex_stat = STAT_OK;
          upd_we  = 1'b1;
          if (cmd_r == CMD_RESUME) begin
            upd_run = 1'b1;
            upd_el  = '0;
          end else if (cmd_r == CMD_SUSPEND) begin
            upd_run = 1'b0;
            upd_el  = '0;
          end else begin
            upd_el  = shf_el;
          end
        end
      end
      default: begin
        ex_stat = STAT_BAD;
        ex_task = '0;
      end
    endcase
  end

  // status to controller
  assign sts_o.in_tick    = (in_tuser == CMD_TICK);
  assign sts_o.count_zero = (cnt_r == '0);
  assign sts_o.scan_last  = (idx_r + CNT_W'(1)) >= cnt_r;
  assign sts_o.stall      = hit && pend_valid_r && !out_free;
  assign sts_o.out_free   = out_free;

  // control state and worst lateness table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      idx_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        worst_r[i] <= '0;
      end
    end else begin
      if (cmd_i.load) begin
        idx_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd_i.step) begin
        idx_r <= idx_r + CNT_W'(1);
        if (hit) begin
          pend_valid_r                   <= 1'b1;
          worst_r[idx_r[TASK_W-1:0]]     <= worst_new;
        end
      end
      if (cmd_i.flush) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd_i.exec && add_we) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers and table contents
  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      cmd_r  <= in_tuser;
      ems_r  <= in_tdata[15:0];
      tidx_r <= in_tdata[18:16];
      ivl_r  <= in_tdata[34:19];
      srun_r <= in_tdata[35];
      dly_r  <= in_tdata[51:36];
      shf_r  <= in_tdata[83:52];
    end
    if (cmd_i.step) begin
      el_mem[idx_r[TASK_W-1:0]] <= hit ? '0 : el_new;
      if (hit) begin
        pend_task_r  <= idx_r[TASK_W-1:0];
        pend_late_r  <= late;
        pend_worst_r <= worst_new;
      end
    end
    if (cmd_i.exec && add_we) begin
      period_mem[cnt_r[TASK_W-1:0]] <= ivl_r;
      run_mem[cnt_r[TASK_W-1:0]]    <= srun_r;
      el_mem[cnt_r[TASK_W-1:0]]     <= {{(EL_W-DLY_W){dly_r[DLY_W-1]}}, dly_r};
    end
    if (cmd_i.exec && upd_we) begin
      run_mem[tidx_r] <= upd_run;
      el_mem[tidx_r]  <= upd_el;
    end
    // output payload
    if (push) begin
      out_stat_r  <= STAT_DISPATCHED;
      out_task_r  <= pend_task_r;
      out_late_r  <= pend_late_r;
      out_worst_r <= pend_worst_r;
      out_last_r  <= 1'b0;
    end else if (cmd_i.exec) begin
      out_stat_r  <= ex_stat;
      out_task_r  <= ex_task;
      out_late_r  <= '0;
      out_worst_r <= '0;
      out_last_r  <= 1'b1;
    end else if (cmd_i.flush) begin
      out_stat_r  <= pend_valid_r ? STAT_DISPATCHED : STAT_NOTHING_DUE;
      out_task_r  <= pend_valid_r ? pend_task_r : '0;
      out_late_r  <= pend_valid_r ? pend_late_r : '0;
      out_worst_r <= pend_valid_r ? pend_worst_r : '0;
      out_last_r  <= 1'b1;
    end
  end

  // output channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_stat_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(OUT_DATA_W-TASK_W-2*LATE_W){1'b0}},
                       out_worst_r, out_late_r, out_task_r};

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TASKS))
    else $error("task count beyond table size");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten while held");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.flush |=> !pend_valid_r)
    else $error("pending dispatch left after flush");

  a_prio_single: assert property (@(posedge clk) disable iff (!rst_n)
    (prio_mode && cmd_i.step && pend_valid_r) |-> !hit)
    else $error("second dispatch in priority mode");

endmodule

`default_nettype wire

@@ rtl/periodic_task_dispatcher.sv @@
// Periodic task dispatcher, top level.
// Input stream: one transaction per command; in_tuser carries the command,
// in_tdata the operands. Result stream: one or more transactions per
// command, out_tlast on the final one; out_tuser carries the status.
// A tick adds the elapsed milliseconds to each running task and
// dispatches due tasks in index order (only the first one when
// priority_mode is set); it emits one transaction per dispatch, or a
// single nothing-due result. Other commands give exactly one result.
// Timing: a tick scans one used table entry per cycle while the receiver
// does not stall, set by the single table read port of the scan; the
// transaction is taken in the idle state and the final result registered
// in the flush state after the scan. Other commands register their result
// in the command state once the output register is free.
// One command is in work at a time.
// Results pass through an output register; while the receiver stalls the
// scan holds at the next dispatch and no new command is taken until the
// current one has placed its last result.
// Reset (rst_n low, synchronous) empties the task table, clears worst
// lateness and priority_mode; no clearing pass is needed.
// Depends on ptd_pkg, ptd_ctrl and ptd_datapath.
`default_nettype none

module periodic_task_dispatcher
  import ptd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // elapsed_ms[15:0], task_index[18:16], interval[34:19],
  // start_running[35], start_delay[51:36], shift_amount[83:52]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command[2:0]
  input  wire logic [CMD_W-1:0]      in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // dispatched_task[2:0], lateness[33:3], worst_lateness[64:34]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // status[2:0]
  output logic [STAT_W-1:0]          out_tuser,
  output logic                       out_tlast,
  // register port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_AW-1:0]     cfg_paddr,
  input  wire logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]          cfg_prdata,
  output logic                       cfg_pready
);

  logic      prio_r;
  logic      reg_sel;
  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  // register decode, word addressed
  assign reg_sel    = (cfg_paddr[CFG_AW-1] == 1'(REG_PRIORITY_MODE));
  assign cfg_pready = 1'b1;
  assign cfg_prdata = reg_sel ? {{(CFG_DW-1){1'b0}}, prio_r} : '0;

  // priority_mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prio_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      prio_r <= cfg_pwdata[0];
    end
  end

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (ctrl_sts),
    .cmd_o     (ctrl_cmd)
  );

  ptd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .prio_mode  (prio_r),
    .cmd_i      (ctrl_cmd),
    .sts_o      (ctrl_sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
